[hw/rtl/bearing_proportional_servo_drive_assert.svh]
// Assertion helpers for the servo drive checker.
// Both expect clk and arst_n in the scope of use.
`ifndef BEARING_PROPORTIONAL_SERVO_DRIVE_ASSERT_SVH
`define BEARING_PROPORTIONAL_SERVO_DRIVE_ASSERT_SVH

// Same-cycle implication.
`define BPSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpsd: same-cycle check failed");

// Next-cycle implication.
`define BPSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpsd: next-cycle check failed");

`endif

[hw/rtl/bpsd_pkg.sv]
package bpsd_pkg;

	// defaults for the top level parameters
	localparam int COORD_BITS_DEF    = 10;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	// configuration port
	localparam int CFG_DW = 10;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_CENTRE_X     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CENTRE_Y     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_TARGET_TWO   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_TARGET_THREE = 3'd3;
	localparam logic [CFG_IW-1:0] REG_TARGET_FOUR  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_TARGET_FIVE  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_GAIN         = 3'd6;
	localparam logic [CFG_IW-1:0] REG_STOP_OFFSET  = 3'd7;

	localparam logic [2:0] CLASS_TWO   = 3'd2;
	localparam logic [2:0] CLASS_THREE = 3'd3;
	localparam logic [2:0] CLASS_FOUR  = 3'd4;
	localparam logic [2:0] CLASS_FIVE  = 3'd5;

	// field widths
	localparam int CENTRE_W = 10;
	localparam int TGT_W    = 9;
	localparam int GAIN_W   = 8;
	localparam int OFF_W    = 7;
	localparam int DRIVE_W  = 8;
	localparam int DEG_W    = 9;
	localparam int ERR_W    = 10;
	localparam int MAG_W    = 9;

	// CORDIC number formats
	localparam int FRAC_BITS = 16;
	localparam int ZW        = 33;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

	// radians (Q30) to degrees: trunc(|z| * 18000 / 314 / 2^30)
	localparam int ABSZ_W          = 32;
	localparam int DEG_MUL_W       = 15;
	localparam logic [DEG_MUL_W-1:0] DEG_MUL = 15'd18000;
	localparam int DEG_SCALE_SHIFT = 30;
	localparam int Q_W             = 17;
	localparam int DEG_DIV         = 314;
	localparam int RECIP_W         = 16;
	localparam logic [RECIP_W-1:0] RECIP_314 = 16'd53430;
	localparam int RECIP_SHIFT     = 24;
	localparam int E_W             = 9;

	// drive law
	localparam logic [DRIVE_W-1:0] DRIVE_NEUTRAL = 8'd90;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX     = 8'd180;
	localparam int DEAD_BAND  = 5;
	localparam int GAIN_SHIFT = 4;

	typedef struct packed {
		logic [CENTRE_W-1:0]     centre_x;
		logic [CENTRE_W-1:0]     centre_y;
		logic signed [TGT_W-1:0] target_two;
		logic signed [TGT_W-1:0] target_three;
		logic signed [TGT_W-1:0] target_four;
		logic signed [TGT_W-1:0] target_five;
		logic [GAIN_W-1:0]       gain;
		logic [OFF_W-1:0]        stop_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		centre_x:     10'd305,
		centre_y:     10'd148,
		target_two:   -9'sd35,
		target_three: -9'sd5,
		target_four:  -9'sd140,
		target_five:  -9'sd175,
		gain:         8'd8,
		stop_offset:  7'd15
	};

	// information that rides alongside the bearing computation
	typedef struct packed {
		logic                    invalid;
		logic                    zero;
		logic signed [TGT_W-1:0] target;
	} side_t;

	// round(atan(2^-i) * 2^30)
	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0:       a = 33'sd843314857;
			1:       a = 33'sd497837829;
			2:       a = 33'sd263043837;
			3:       a = 33'sd133525159;
			4:       a = 33'sd67021687;
			5:       a = 33'sd33543516;
			6:       a = 33'sd16775851;
			7:       a = 33'sd8388437;
			8:       a = 33'sd4194283;
			9:       a = 33'sd2097149;
			10:      a = 33'sd1048576;
			11:      a = 33'sd524288;
			12:      a = 33'sd262144;
			13:      a = 33'sd131072;
			14:      a = 33'sd65536;
			15:      a = 33'sd32768;
			16:      a = 33'sd16384;
			17:      a = 33'sd8192;
			18:      a = 33'sd4096;
			19:      a = 33'sd2048;
			20:      a = 33'sd1024;
			21:      a = 33'sd512;
			22:      a = 33'sd256;
			23:      a = 33'sd128;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/bearing_proportional_servo_drive.sv]
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  position_x, position_y, bin_class
// output    out        out_valid/out_stall drive_value, aligned, class_invalid
// config    in         cfg_wen            cfg_index, cfg_data (no read-back)
//
// One transaction per cycle sustained while out_stall is low; the unrolled
// CORDIC does one rotation per stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled output holds only the full stages behind it: empty stages still
// fill, so in_stall rises only when every stage is occupied and out_stall is high.
module bearing_proportional_servo_drive #(
	parameter int COORD_BITS    = bpsd_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = bpsd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [COORD_BITS-1:0]          position_x,
	input  logic [COORD_BITS-1:0]          position_y,
	input  logic [2:0]                     bin_class,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bpsd_pkg::DRIVE_W-1:0]   drive_value,
	output logic                           aligned,
	output logic                           class_invalid,
	// configuration writes
	input  logic                           cfg_wen,
	input  logic [bpsd_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [bpsd_pkg::CFG_DW-1:0]    cfg_data
);

	// datapath width: sign, coordinate, CORDIC growth and fraction
	localparam int XW      = COORD_BITS + bpsd_pkg::FRAC_BITS + 3;
	localparam int FRONT0  = 0;
	localparam int CORDIC0 = 2;
	localparam int DEG0    = CORDIC0 + CORDIC_STAGES;
	localparam int DRV0    = DEG0 + 4;
	localparam int NSTG    = DRV0 + 3;

	bpsd_pkg::cfg_t cfg_q;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] hold;
	logic [NSTG-1:0] ld;

	logic signed [XW-1:0]            x_c [CORDIC_STAGES+1];
	logic signed [XW-1:0]            y_c [CORDIC_STAGES+1];
	logic signed [bpsd_pkg::ZW-1:0]  z_c [CORDIC_STAGES+1];
	bpsd_pkg::side_t                 side_c [CORDIC_STAGES+1];

	logic signed [bpsd_pkg::DEG_W-1:0] deg;
	bpsd_pkg::side_t                   side_deg;

	// register file; the user must write only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bpsd_pkg::CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				bpsd_pkg::REG_CENTRE_X:
					cfg_q.centre_x <= cfg_data[bpsd_pkg::CENTRE_W-1:0];
				bpsd_pkg::REG_CENTRE_Y:
					cfg_q.centre_y <= cfg_data[bpsd_pkg::CENTRE_W-1:0];
				bpsd_pkg::REG_TARGET_TWO:
					cfg_q.target_two <= $signed(cfg_data[bpsd_pkg::TGT_W-1:0]);
				bpsd_pkg::REG_TARGET_THREE:
					cfg_q.target_three <= $signed(cfg_data[bpsd_pkg::TGT_W-1:0]);
				bpsd_pkg::REG_TARGET_FOUR:
					cfg_q.target_four <= $signed(cfg_data[bpsd_pkg::TGT_W-1:0]);
				bpsd_pkg::REG_TARGET_FIVE:
					cfg_q.target_five <= $signed(cfg_data[bpsd_pkg::TGT_W-1:0]);
				bpsd_pkg::REG_GAIN:
					cfg_q.gain <= cfg_data[bpsd_pkg::GAIN_W-1:0];
				bpsd_pkg::REG_STOP_OFFSET:
					cfg_q.stop_offset <= cfg_data[bpsd_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage holds when it and every stage after it are full and the output
	// is stalled; otherwise it advances, so bubbles are squeezed out.
	for (genvar k = 0; k < NSTG; k++) begin : g_hold
		assign hold[k] = out_stall && (&vld_q[NSTG-1:k]);
		assign ld[k]   = !hold[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = hold[0];
	assign out_valid = vld_q[NSTG-1];

	// centre offsets, class lookup and quarter-turn fold
	bpsd_front #(
		.COORD_BITS(COORD_BITS),
		.XW        (XW)
	) u_front (
		.clk       (clk),
		.ld        (ld[FRONT0 +: 2]),
		.position_x(position_x),
		.position_y(position_y),
		.bin_class (bin_class),
		.cfg       (cfg_q),
		.x_o       (x_c[0]),
		.y_o       (y_c[0]),
		.z_o       (z_c[0]),
		.side_o    (side_c[0])
	);

	// unrolled vectoring CORDIC, one rotation per stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		bpsd_cordic_stage #(
			.XW   (XW),
			.SHIFT(i)
		) u_stage (
			.clk   (clk),
			.ld    (ld[CORDIC0 + i]),
			.x_i   (x_c[i]),
			.y_i   (y_c[i]),
			.z_i   (z_c[i]),
			.side_i(side_c[i]),
			.x_o   (x_c[i+1]),
			.y_o   (y_c[i+1]),
			.z_o   (z_c[i+1]),
			.side_o(side_c[i+1])
		);
	end

	// angle to whole degrees, truncated toward zero
	bpsd_degrees u_degrees (
		.clk   (clk),
		.ld    (ld[DEG0 +: 4]),
		.z_i   (z_c[CORDIC_STAGES]),
		.side_i(side_c[CORDIC_STAGES]),
		.deg_o (deg),
		.side_o(side_deg)
	);

	// error, dead band, gain and clamp; last stage is the output register
	bpsd_drive u_drive (
		.clk          (clk),
		.ld           (ld[DRV0 +: 3]),
		.deg_i        (deg),
		.side_i       (side_deg),
		.cfg          (cfg_q),
		.drive_value  (drive_value),
		.aligned      (aligned),
		.class_invalid(class_invalid)
	);

endmodule

[hw/rtl/bpsd_front.sv]
module bpsd_front #(
	parameter int COORD_BITS = bpsd_pkg::COORD_BITS_DEF,
	parameter int XW         = COORD_BITS + bpsd_pkg::FRAC_BITS + 3
) (
	input  logic                             clk,
	input  logic [1:0]                       ld,
	input  logic [COORD_BITS-1:0]            position_x,
	input  logic [COORD_BITS-1:0]            position_y,
	input  logic [2:0]                       bin_class,
	input  bpsd_pkg::cfg_t                   cfg,
	output logic signed [XW-1:0]             x_o,
	output logic signed [XW-1:0]             y_o,
	output logic signed [bpsd_pkg::ZW-1:0]   z_o,
	output bpsd_pkg::side_t                  side_o
);

	localparam int DW  = COORD_BITS + 1;
	localparam int EXT = XW - DW - bpsd_pkg::FRAC_BITS;

	logic [COORD_BITS-1:0]   cx, cy;
	logic signed [DW-1:0]    dx_n, dy_n;
	bpsd_pkg::side_t         side_n;

	logic signed [DW-1:0]    dx_s1, dy_s1;
	bpsd_pkg::side_t         side_s1;

	logic signed [DW-1:0]              rx, ry;
	logic signed [bpsd_pkg::ZW-1:0]    rz;

	logic signed [XW-1:0]              x_s2, y_s2;
	logic signed [bpsd_pkg::ZW-1:0]    z_s2;
	bpsd_pkg::side_t                   side_s2;

	// differences from the turntable centre, class lookup
	always_comb begin
		cx   = COORD_BITS'(cfg.centre_x);
		cy   = COORD_BITS'(cfg.centre_y);
		dx_n = $signed({1'b0, position_x}) - $signed({1'b0, cx});
		dy_n = $signed({1'b0, cy}) - $signed({1'b0, position_y});
		side_n.zero    = (position_x == cx) && (position_y == cy);
		side_n.invalid = 1'b0;
		case (bin_class)
			bpsd_pkg::CLASS_TWO:   side_n.target = cfg.target_two;
			bpsd_pkg::CLASS_THREE: side_n.target = cfg.target_three;
			bpsd_pkg::CLASS_FOUR:  side_n.target = cfg.target_four;
			bpsd_pkg::CLASS_FIVE:  side_n.target = cfg.target_five;
			default: begin
				side_n.target  = '0;
				side_n.invalid = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			dx_s1   <= dx_n;
			dy_s1   <= dy_n;
			side_s1 <= side_n;
		end
	end

	// fold the left half plane into the right by a quarter turn
	always_comb begin
		if (!dx_s1[DW-1]) begin
			rx = dx_s1;
			ry = dy_s1;
			rz = '0;
		end else if (!dy_s1[DW-1]) begin
			rx = dy_s1;
			ry = -dx_s1;
			rz = bpsd_pkg::HALF_PI_Q30;
		end else begin
			rx = -dy_s1;
			ry = dx_s1;
			rz = -bpsd_pkg::HALF_PI_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			x_s2    <= {{EXT{rx[DW-1]}}, rx, {bpsd_pkg::FRAC_BITS{1'b0}}};
			y_s2    <= {{EXT{ry[DW-1]}}, ry, {bpsd_pkg::FRAC_BITS{1'b0}}};
			z_s2    <= rz;
			side_s2 <= side_s1;
		end
	end

	assign x_o    = x_s2;
	assign y_o    = y_s2;
	assign z_o    = z_s2;
	assign side_o = side_s2;

endmodule

[hw/rtl/bpsd_cordic_stage.sv]
module bpsd_cordic_stage #(
	parameter int XW    = bpsd_pkg::COORD_BITS_DEF + bpsd_pkg::FRAC_BITS + 3,
	parameter int SHIFT = 0
) (
	input  logic                             clk,
	input  logic                             ld,
	input  logic signed [XW-1:0]             x_i,
	input  logic signed [XW-1:0]             y_i,
	input  logic signed [bpsd_pkg::ZW-1:0]   z_i,
	input  bpsd_pkg::side_t                  side_i,
	output logic signed [XW-1:0]             x_o,
	output logic signed [XW-1:0]             y_o,
	output logic signed [bpsd_pkg::ZW-1:0]   z_o,
	output bpsd_pkg::side_t                  side_o
);

	localparam logic signed [bpsd_pkg::ZW-1:0] ANGLE = bpsd_pkg::atan_q30(SHIFT);

	logic signed [XW-1:0]            xs, ys;
	logic signed [XW-1:0]            x_s1, y_s1;
	logic signed [bpsd_pkg::ZW-1:0]  z_s1;
	bpsd_pkg::side_t                 side_s1;

	// arithmetic shifts round toward minus infinity
	assign xs = x_i >>> SHIFT;
	assign ys = y_i >>> SHIFT;

	// rotate towards the x axis
	always_ff @(posedge clk) begin
		if (ld) begin
			if (!y_i[XW-1]) begin
				x_s1 <= x_i + ys;
				y_s1 <= y_i - xs;
				z_s1 <= z_i + ANGLE;
			end else begin
				x_s1 <= x_i - ys;
				y_s1 <= y_i + xs;
				z_s1 <= z_i - ANGLE;
			end
			side_s1 <= side_i;
		end
	end

	assign x_o    = x_s1;
	assign y_o    = y_s1;
	assign z_o    = z_s1;
	assign side_o = side_s1;

endmodule

[hw/rtl/bpsd_degrees.sv]
module bpsd_degrees (
	input  logic                                 clk,
	input  logic [3:0]                           ld,
	input  logic signed [bpsd_pkg::ZW-1:0]       z_i,
	input  bpsd_pkg::side_t                      side_i,
	output logic signed [bpsd_pkg::DEG_W-1:0]    deg_o,
	output bpsd_pkg::side_t                      side_o
);

	localparam int PROD_W  = bpsd_pkg::ABSZ_W + bpsd_pkg::DEG_MUL_W;
	localparam int RPROD_W = bpsd_pkg::Q_W + bpsd_pkg::RECIP_W;

	logic [bpsd_pkg::ABSZ_W-1:0]   absz_s1;
	logic                          neg_s1, neg_s2, neg_s3;
	bpsd_pkg::side_t               side_s1, side_s2, side_s3, side_s4;

	logic [PROD_W-1:0]             prod;
	logic [bpsd_pkg::Q_W-1:0]      q_s2, q_s3;

	logic [RPROD_W-1:0]            rprod;
	logic [bpsd_pkg::E_W-1:0]      e_s3;

	logic [bpsd_pkg::Q_W-1:0]      eq, rem;
	logic [bpsd_pkg::E_W-1:0]      mag;
	logic signed [bpsd_pkg::DEG_W-1:0] deg_s4;

	// magnitude of the angle, truncation works on it
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			absz_s1 <= bpsd_pkg::ABSZ_W'(z_i[bpsd_pkg::ZW-1] ? -z_i : z_i);
			neg_s1  <= z_i[bpsd_pkg::ZW-1];
			side_s1 <= side_i;
		end
	end

	// scale to hundredths of the divisor and drop the Q30 fraction
	assign prod = PROD_W'(absz_s1) * PROD_W'(bpsd_pkg::DEG_MUL);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			q_s2    <= prod[bpsd_pkg::DEG_SCALE_SHIFT +: bpsd_pkg::Q_W];
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// quotient estimate by reciprocal, low by at most one
	assign rprod = RPROD_W'(q_s2) * RPROD_W'(bpsd_pkg::RECIP_314);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			e_s3    <= rprod[bpsd_pkg::RECIP_SHIFT +: bpsd_pkg::E_W];
			q_s3    <= q_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	always_comb begin
		eq  = bpsd_pkg::Q_W'(e_s3) * bpsd_pkg::Q_W'(bpsd_pkg::DEG_DIV);
		rem = q_s3 - eq;
		mag = (rem >= bpsd_pkg::Q_W'(bpsd_pkg::DEG_DIV)) ? e_s3 + 1'b1 : e_s3;
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			if (side_s3.zero)
				deg_s4 <= '0;
			else if (neg_s3)
				deg_s4 <= -$signed(mag);
			else
				deg_s4 <= $signed(mag);
			side_s4 <= side_s3;
		end
	end

	assign deg_o  = deg_s4;
	assign side_o = side_s4;

endmodule

[hw/rtl/bpsd_drive.sv]
module bpsd_drive (
	input  logic                                clk,
	input  logic [2:0]                          ld,
	input  logic signed [bpsd_pkg::DEG_W-1:0]   deg_i,
	input  bpsd_pkg::side_t                     side_i,
	input  bpsd_pkg::cfg_t                      cfg,
	output logic [bpsd_pkg::DRIVE_W-1:0]        drive_value,
	output logic                                aligned,
	output logic                                class_invalid
);

	localparam int PROD_W = bpsd_pkg::MAG_W + bpsd_pkg::GAIN_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int STEP_W = PROD_W - bpsd_pkg::GAIN_SHIFT + 1;
	localparam int SUM_W  = STEP_W + 1;

	logic signed [bpsd_pkg::ERR_W-1:0] err;
	logic [bpsd_pkg::MAG_W-1:0]        mag_n;

	logic [bpsd_pkg::MAG_W-1:0] mag_s1;
	logic                       pos_s1, neg_s1, al_s1, inv_s1;

	logic [PROD_W-1:0]          prod_s2;
	logic                       pos_s2, neg_s2, al_s2, inv_s2;

	logic [STEP_W-1:0]          step_dn;
	logic [SUM_W-1:0]           up, sub;
	logic [bpsd_pkg::DRIVE_W-1:0] up_c, dn_c, drive_n;

	logic [bpsd_pkg::DRIVE_W-1:0] drive_s3;
	logic                         al_s3, inv_s3;

	always_comb begin
		err = bpsd_pkg::ERR_W'(deg_i) - bpsd_pkg::ERR_W'(side_i.target);
		mag_n = bpsd_pkg::MAG_W'(err[bpsd_pkg::ERR_W-1] ? -err : err);
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			mag_s1 <= mag_n;
			pos_s1 <= err > bpsd_pkg::ERR_W'(bpsd_pkg::DEAD_BAND);
			neg_s1 <= err < -bpsd_pkg::ERR_W'(bpsd_pkg::DEAD_BAND);
			al_s1  <= mag_n < bpsd_pkg::MAG_W'(bpsd_pkg::DEAD_BAND);
			inv_s1 <= side_i.invalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(cfg.gain);
			pos_s2  <= pos_s1;
			neg_s2  <= neg_s1;
			al_s2   <= al_s1;
			inv_s2  <= inv_s1;
		end
	end

	// floor above the band, ceiling below it, then clamp to the servo range
	always_comb begin
		step_dn = STEP_W'((RND_W'(prod_s2) + RND_W'(4'hF)) >> bpsd_pkg::GAIN_SHIFT);
		up  = SUM_W'(bpsd_pkg::DRIVE_NEUTRAL) + SUM_W'(cfg.stop_offset)
			+ SUM_W'(prod_s2 >> bpsd_pkg::GAIN_SHIFT);
		sub = SUM_W'(cfg.stop_offset) + SUM_W'(step_dn);
		up_c = (up > SUM_W'(bpsd_pkg::DRIVE_MAX)) ? bpsd_pkg::DRIVE_MAX
			: bpsd_pkg::DRIVE_W'(up);
		dn_c = (sub >= SUM_W'(bpsd_pkg::DRIVE_NEUTRAL)) ? '0
			: bpsd_pkg::DRIVE_NEUTRAL - bpsd_pkg::DRIVE_W'(sub);
		if (inv_s2)
			drive_n = bpsd_pkg::DRIVE_NEUTRAL;
		else if (pos_s2)
			drive_n = up_c;
		else if (neg_s2)
			drive_n = dn_c;
		else
			drive_n = bpsd_pkg::DRIVE_NEUTRAL;
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			drive_s3 <= drive_n;
			al_s3    <= al_s2 && !inv_s2;
			inv_s3   <= inv_s2;
		end
	end

	assign drive_value   = drive_s3;
	assign aligned       = al_s3;
	assign class_invalid = inv_s3;

endmodule

[hw/rtl/bpsd_checker.sv]
`include "bearing_proportional_servo_drive_assert.svh"

module bpsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [bpsd_pkg::DRIVE_W-1:0]  drive_value,
	input logic                          aligned,
	input logic                          class_invalid
);

	`BPSD_ASSERT_NOW(a_drive_range, out_valid, drive_value <= bpsd_pkg::DRIVE_MAX)
	`BPSD_ASSERT_NOW(a_invalid_neutral, out_valid && class_invalid, drive_value == bpsd_pkg::DRIVE_NEUTRAL && !aligned)
	`BPSD_ASSERT_NOW(a_aligned_neutral, out_valid && aligned, drive_value == bpsd_pkg::DRIVE_NEUTRAL)
	`BPSD_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
	`BPSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive_value) && $stable(aligned) && $stable(class_invalid))

endmodule

bind bearing_proportional_servo_drive bpsd_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.drive_value  (drive_value),
	.aligned      (aligned),
	.class_invalid(class_invalid)
);
